[hdl/format_string_integer_printer_assert.svh]
// Assertion macros for the integer printf engine.
// Included by the top level; the bodies vanish when SYNTHESIS is defined.
`ifndef FORMAT_STRING_INTEGER_PRINTER_ASSERT_SVH
`define FORMAT_STRING_INTEGER_PRINTER_ASSERT_SVH

`ifndef SYNTHESIS
`define FSIP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FSIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FSIP_ASSERT(lbl, clk, rstn, prop, msg)
`define FSIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hdl/fsip_pkg.sv]
// Shared types and constants of the integer printf engine.
// Used by the digit unit and the top level; depends on nothing.
package fsip_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned WidthW  = 6;
  localparam int unsigned DigN    = 10;
  localparam int unsigned DigIdxW = 4;

  localparam logic [31:0] Recip10  = 32'hCCCC_CCCD;
  localparam int unsigned DecShift = 35;
  localparam int unsigned QuoW     = 64 - DecShift;

  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChC     = 8'h63;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef struct packed {
    logic load;
    logic mul;
    logic rem;
    logic hex;
  } unit_ctl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = ChZero + {4'b0, d};
    end else begin
      r = ChLowA + {4'b0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

[hdl/fsip_digit_unit.sv]
// Shared digit unit: peels one decimal or hex digit off a working value.
// Decimal takes a reciprocal multiply step and a remainder step; depends on fsip_pkg.
module fsip_digit_unit (
  input  logic                clk_i,
  input  fsip_pkg::unit_ctl_t ctl_i,
  input  logic [31:0]         value_i,
  output logic [3:0]          digit_o,
  output logic                last_o
);
  import fsip_pkg::*;

  logic [31:0]     val_q, val_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [63:0]     prod;
  logic [31:0]     quo_ext;
  logic [31:0]     quo_x10;
  logic [31:0]     rem;

  assign prod    = {32'b0, val_q} * {32'b0, Recip10};
  assign quo_ext = {{(32 - QuoW){1'b0}}, quo_q};
  assign quo_x10 = (quo_ext << 3) + (quo_ext << 1);
  assign rem     = val_q - quo_x10;

  always_comb begin
    val_d   = val_q;
    quo_d   = quo_q;
    digit_o = rem[3:0];
    last_o  = (quo_q == '0);
    if (ctl_i.load) begin
      val_d = value_i;
    end else if (ctl_i.mul) begin
      quo_d = prod[63:DecShift];
    end else if (ctl_i.rem) begin
      val_d = quo_ext;
    end else if (ctl_i.hex) begin
      val_d = val_q >> 4;
    end
    if (ctl_i.hex) begin
      digit_o = val_q[3:0];
      last_o  = (val_q[31:4] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    quo_q <= quo_d;
  end

endmodule

[hdl/format_string_integer_printer.sv]
// Top level of the integer printf engine: parser, sequencer, output register.
// Depends on fsip_pkg, fsip_digit_unit and format_string_integer_printer_assert.svh.
//
// One format byte is taken per beat and expanded into character beats. A literal
// byte, a flag or width digit, a percent sign or an unknown letter is handled on
// acceptance. A conversion first runs the shared digit unit, a multiply and a remainder
// step per decimal digit or one step per hex digit, sizes the padding in S_PREP, and
// then sends one character per cycle while the output is not stalled, up to MAX_WIDTH
// characters. An end beat sends the terminator, after a question mark when a directive
// is still open. The block takes no new beat while it works.
module format_string_integer_printer #(
  parameter int unsigned MAX_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  fmt_char_i,
  input  logic [31:0] arg_value_i,
  input  logic        end_of_format_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic [15:0] position_o,
  output logic        fits_o,
  output logic        is_terminator_o,
  output logic [15:0] total_count_o,
  output logic        last_of_run_o
);
  import fsip_pkg::*;

  localparam logic [WidthW-1:0] MaxW  = WidthW'(MAX_WIDTH);
  localparam logic [9:0]        MaxW10 = 10'(MAX_WIDTH);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MUL   = 11'b000_0000_0010,
    S_REM   = 11'b000_0000_0100,
    S_HEX   = 11'b000_0000_1000,
    S_PREP  = 11'b000_0001_0000,
    S_SIGN1 = 11'b000_0010_0000,
    S_PAD   = 11'b000_0100_0000,
    S_SIGN2 = 11'b000_1000_0000,
    S_DIGIT = 11'b001_0000_0000,
    S_CHAR  = 11'b010_0000_0000,
    S_TERM  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    PM_LIT = 3'b001,
    PM_PCT = 3'b010,
    PM_WID = 3'b100
  } mode_e;

  state_e              state_q, state_d, after_pad;
  mode_e               mode_q, mode_d;
  logic                pz_q, pz_d;
  logic [WidthW-1:0]   fw_q, fw_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [15:0]         bs_q;
  logic                neg_q, neg_d;
  logic                chr_q, chr_d;
  logic [7:0]          char_q, char_d;
  logic [DigIdxW-1:0]  n_q, n_d;
  logic [DigIdxW-1:0]  idx_q, idx_d;
  logic [WidthW-1:0]   pad_q, pad_d;
  logic [3:0]          dig_q [DigN];

  logic                out_valid_q;
  logic [7:0]          out_char_q;
  logic [15:0]         pos_q;
  logic                fits_q, term_q, last_q;
  logic [15:0]         total_q;

  logic                slot_free, in_acc;
  logic                emit, emit_term, emit_last;
  logic [7:0]          emit_char;
  logic [7:0]          o_char_d;
  logic [15:0]         o_pos_d, o_total_d;
  logic                o_fits_d, o_last_d;
  logic [15:0]         bs_m1;
  logic                pz_eff;
  logic [7:0]          pad_char;
  logic [9:0]          fw_ext, fw_next;
  logic [WidthW-1:0]   len;
  logic [31:0]         mag;
  logic                dig_we;
  unit_ctl_t           ctl;
  logic [3:0]          unit_digit;
  logic                unit_last;

  fsip_digit_unit u_digit (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .value_i (mag),
    .digit_o (unit_digit),
    .last_o  (unit_last)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign bs_m1      = bs_q - 16'd1;
  assign pz_eff     = pz_q && !chr_q;
  assign pad_char   = pz_eff ? ChZero : ChSpace;
  assign fw_ext     = {4'b0, fw_q};
  assign fw_next    = (fw_ext << 3) + (fw_ext << 1) + {6'b0, fmt_char_i[3:0]};
  assign len        = {2'b0, n_q} + {{(WidthW - 1){1'b0}}, neg_q};
  assign mag        = (fmt_char_i == ChD && arg_value_i[31]) ? (~arg_value_i + 32'd1)
                                                             : arg_value_i;
  assign after_pad  = (neg_q && !pz_eff) ? S_SIGN2 : (chr_q ? S_CHAR : S_DIGIT);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    pz_d      = pz_q;
    fw_d      = fw_q;
    neg_d     = neg_q;
    chr_d     = chr_q;
    char_d    = char_q;
    n_d       = n_q;
    idx_d     = idx_q;
    pad_d     = pad_q;
    emit      = 1'b0;
    emit_term = 1'b0;
    emit_last = 1'b0;
    emit_char = ChQuest;
    dig_we    = 1'b0;
    ctl       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (end_of_format_i) begin
            if (mode_q != PM_LIT) begin
              emit    = 1'b1;
              state_d = S_TERM;
            end else begin
              emit_term = 1'b1;
            end
            mode_d = PM_LIT;
            pz_d   = 1'b0;
            fw_d   = '0;
          end else if (mode_q == PM_LIT) begin
            if (fmt_char_i == ChPct) begin
              mode_d = PM_PCT;
              pz_d   = 1'b0;
              fw_d   = '0;
            end else begin
              emit      = 1'b1;
              emit_last = 1'b1;
              emit_char = fmt_char_i;
            end
          end else if (mode_q == PM_PCT && fmt_char_i == ChZero) begin
            pz_d   = 1'b1;
            mode_d = PM_WID;
          end else if (fmt_char_i inside {[ChZero:ChNine]}) begin
            fw_d   = (fw_next > MaxW10) ? MaxW : fw_next[WidthW-1:0];
            mode_d = PM_WID;
          end else begin
            mode_d = PM_LIT;
            n_d    = '0;
            neg_d  = 1'b0;
            chr_d  = 1'b0;
            case (fmt_char_i)
              ChPct: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_char = ChPct;
              end
              ChC: begin
                chr_d   = 1'b1;
                n_d     = DigIdxW'(1);
                char_d  = arg_value_i[7:0];
                state_d = S_PREP;
              end
              ChD: begin
                ctl.load = 1'b1;
                neg_d    = arg_value_i[31];
                state_d  = S_MUL;
              end
              ChU: begin
                ctl.load = 1'b1;
                state_d  = S_MUL;
              end
              ChX: begin
                ctl.load = 1'b1;
                state_d  = S_HEX;
              end
              default: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_char = ChQuest;
              end
            endcase
          end
        end
      end
      S_MUL: begin
        ctl.mul = 1'b1;
        state_d = S_REM;
      end
      S_REM: begin
        ctl.rem = 1'b1;
        dig_we  = 1'b1;
        n_d     = n_q + DigIdxW'(1);
        state_d = unit_last ? S_PREP : S_MUL;
      end
      S_HEX: begin
        ctl.hex = 1'b1;
        dig_we  = 1'b1;
        n_d     = n_q + DigIdxW'(1);
        state_d = unit_last ? S_PREP : S_HEX;
      end
      S_PREP: begin
        pad_d = (fw_q > len) ? (fw_q - len) : '0;
        idx_d = n_q - DigIdxW'(1);
        if (neg_q && pz_eff) begin
          state_d = S_SIGN1;
        end else if (pad_d != '0) begin
          state_d = S_PAD;
        end else begin
          state_d = after_pad;
        end
      end
      S_SIGN1: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = ChMinus;
          state_d   = (pad_q != '0) ? S_PAD : S_DIGIT;
        end
      end
      S_PAD: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = pad_char;
          pad_d     = pad_q - WidthW'(1);
          if (pad_q == WidthW'(1)) begin
            state_d = after_pad;
          end
        end
      end
      S_SIGN2: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = ChMinus;
          state_d   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = digit_char(dig_q[idx_q]);
          if (idx_q == '0) begin
            emit_last = 1'b1;
            state_d   = S_IDLE;
          end else begin
            idx_d = idx_q - DigIdxW'(1);
          end
        end
      end
      S_CHAR: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_char = char_q;
          state_d   = S_IDLE;
        end
      end
      S_TERM: begin
        if (slot_free) begin
          emit_term = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d     = cnt_q;
    o_char_d  = emit_char;
    o_pos_d   = cnt_q;
    o_fits_d  = ({1'b0, cnt_q} + 17'd1) < {1'b0, bs_q};
    o_last_d  = emit_last;
    o_total_d = cnt_q;
    if (emit) begin
      if (cnt_q != '1) begin
        cnt_d = cnt_q + CountW'(1);
      end
      o_total_d = cnt_d;
    end
    if (emit_term) begin
      cnt_d     = '0;
      o_char_d  = ChNul;
      o_last_d  = 1'b1;
      o_fits_d  = (bs_q != '0);
      o_total_d = cnt_q;
      if (bs_q == '0) begin
        o_pos_d = '0;
      end else begin
        o_pos_d = (cnt_q < bs_m1) ? cnt_q : bs_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= PM_LIT;
      pz_q        <= 1'b0;
      fw_q        <= '0;
      cnt_q       <= '0;
      bs_q        <= 16'd256;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      pad_q       <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      pz_q    <= pz_d;
      fw_q    <= fw_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      pad_q   <= pad_d;
      if (cfg_we_i) begin
        bs_q <= cfg_wdata_i;
      end
      if (emit || emit_term) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    chr_q  <= chr_d;
    char_q <= char_d;
    if (dig_we) begin
      dig_q[n_q] <= unit_digit;
    end
    if (emit || emit_term) begin
      out_char_q <= o_char_d;
      pos_q      <= o_pos_d;
      fits_q     <= o_fits_d;
      term_q     <= emit_term;
      last_q     <= o_last_d;
      total_q    <= o_total_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign position_o      = pos_q;
  assign fits_o          = fits_q;
  assign is_terminator_o = term_q;
  assign total_count_o   = total_q;
  assign last_of_run_o   = last_q;

`include "format_string_integer_printer_assert.svh"

  `FSIP_ASSERT(a_term_last, clk_i, rst_ni, !(out_valid_o && is_terminator_o) || last_of_run_o, "terminator beat must close its run")
  `FSIP_ASSERT_NEXT(a_term_clears, clk_i, rst_ni, emit_term, cnt_q == '0, "count not cleared after terminator")
  `FSIP_ASSERT(a_fits_cap, clk_i, rst_ni, !(out_valid_o && fits_o && !is_terminator_o) || (({1'b0, position_o} + 17'd1) < {1'b0, bs_q}), "fits flag set beyond capacity")
  `FSIP_ASSERT(a_busy_no_emit, clk_i, rst_ni, !(emit && !slot_free), "character sent while output register is full")

endmodule

[test/printf_stream_checker.sv]
// Watches both channels of the integer printf engine, predicts each character beat and
// compares it with what the engine sends. Depends on fsip_pkg for the character constants.
module printf_stream_checker #(
  parameter int unsigned MaxWidth = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  fmt_char_i,
  input  logic [31:0] arg_value_i,
  input  logic        end_of_format_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,
  input  logic [15:0] position_i,
  input  logic        fits_i,
  input  logic        is_terminator_i,
  input  logic [15:0] total_count_i,
  input  logic        last_of_run_i,
  output int unsigned pending_o,
  output int unsigned failures_o
);
  import fsip_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef enum logic [1:0] {
    ModeLiteral,
    ModePercent,
    ModeWidth
  } parse_mode_e;

  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] pos;
    logic        fits;
    logic        term;
    logic [15:0] total;
    logic        last;
  } char_beat_t;

  char_beat_t   expected_chars[$];
  logic [7:0]   digit_q[$];
  logic [15:0]  buffer_size;
  parse_mode_e  parse_mode;
  logic         zero_pad;
  int unsigned  field_width;
  logic [15:0]  char_count;
  int unsigned  mismatches = 0;

  assign failures_o = mismatches;

  function automatic void put_char(input logic [7:0] ch);
    char_beat_t b;
    b.ch   = ch;
    b.pos  = char_count;
    b.fits = (int'(char_count) + 1 < int'(buffer_size));
    if (char_count != 16'hFFFF) begin
      char_count = char_count + 16'd1;
    end
    b.term  = 1'b0;
    b.total = char_count;
    b.last  = 1'b0;
    expected_chars.push_back(b);
  endfunction

  function automatic void pad_to(input logic [7:0] ch, input int unsigned len);
    for (int unsigned i = len; i < field_width; i++) begin
      put_char(ch);
    end
  endfunction

  function automatic void spell_number(input logic [31:0] v, input int unsigned base);
    logic [31:0] rest;
    logic [31:0] dig;
    digit_q.delete();
    rest = v;
    do begin
      dig = rest % base;
      digit_q.push_front(dig < 10 ? ChZero + dig[7:0] : ChLowA + dig[7:0] - 8'd10);
      rest = rest / base;
    end while (rest != 0);
  endfunction

  function automatic void convert(input logic [7:0] letter, input logic [31:0] arg);
    logic        neg;
    logic [31:0] mag;
    int unsigned len;
    case (letter)
      ChPct: begin
        put_char(ChPct);
      end
      ChC: begin
        pad_to(ChSpace, 1);
        put_char(arg[7:0]);
      end
      ChD: begin
        neg = arg[31];
        mag = neg ? ~arg + 32'd1 : arg;
        spell_number(mag, 10);
        len = digit_q.size() + (neg ? 1 : 0);
        if (neg && zero_pad) begin
          put_char(ChMinus);
          pad_to(ChZero, len);
        end else begin
          pad_to(zero_pad ? ChZero : ChSpace, len);
          if (neg) begin
            put_char(ChMinus);
          end
        end
        foreach (digit_q[k]) put_char(digit_q[k]);
      end
      ChU, ChX: begin
        spell_number(arg, letter == ChX ? 16 : 10);
        pad_to(zero_pad ? ChZero : ChSpace, digit_q.size());
        foreach (digit_q[k]) put_char(digit_q[k]);
      end
      default: begin
        put_char(ChQuest);
      end
    endcase
    parse_mode = ModeLiteral;
  endfunction

  function automatic void expand_format_byte(input logic [7:0] fmt, input logic [31:0] arg,
                                             input logic eof);
    int unsigned first;
    char_beat_t  b;
    first = expected_chars.size();
    if (eof) begin
      if (parse_mode != ModeLiteral) begin
        put_char(ChQuest);
      end
      b       = '0;
      b.term  = 1'b1;
      b.total = char_count;
      if (buffer_size != 16'd0) begin
        b.pos  = char_count < buffer_size - 16'd1 ? char_count : buffer_size - 16'd1;
        b.fits = 1'b1;
      end
      expected_chars.push_back(b);
      parse_mode  = ModeLiteral;
      zero_pad    = 1'b0;
      field_width = 0;
      char_count  = 16'd0;
    end else if (parse_mode == ModeLiteral) begin
      if (fmt == ChPct) begin
        parse_mode  = ModePercent;
        zero_pad    = 1'b0;
        field_width = 0;
      end else begin
        put_char(fmt);
      end
    end else if (parse_mode == ModePercent && fmt == ChZero) begin
      zero_pad   = 1'b1;
      parse_mode = ModeWidth;
    end else if (fmt >= ChZero && fmt <= ChNine) begin
      field_width = field_width * 10 + int'(fmt - ChZero);
      if (field_width > MaxWidth) begin
        field_width = MaxWidth;
      end
      parse_mode = ModeWidth;
    end else begin
      convert(fmt, arg);
    end
    if (expected_chars.size() > first) begin
      b = expected_chars.pop_back();
      b.last = 1'b1;
      expected_chars.push_back(b);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_beat_t want;
    char_beat_t got;
    if (!rst_ni) begin
      expected_chars.delete();
      buffer_size = 16'd256;
      parse_mode  = ModeLiteral;
      zero_pad    = 1'b0;
      field_width = 0;
      char_count  = 16'd0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        buffer_size = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        expand_format_byte(fmt_char_i, arg_value_i, end_of_format_i);
      end
      if (out_valid_i && out_ready_i) begin
        got = {out_char_i, position_i, fits_i, is_terminator_i, total_count_i, last_of_run_i};
        if (expected_chars.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("unexpected beat: char %02h pos %0d fits %0b term %0b total %0d last %0b",
                     got.ch, got.pos, got.fits, got.term, got.total, got.last);
          end
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) begin
            if (mismatches < ReportLimit) begin
              $display("mismatch: expected char %02h pos %0d fits %0b term %0b total %0d last %0b",
                       want.ch, want.pos, want.fits, want.term, want.total, want.last);
              $display("          actual   char %02h pos %0d fits %0b term %0b total %0d last %0b",
                       got.ch, got.pos, got.fits, got.term, got.total, got.last);
            end
            mismatches++;
          end
        end
      end
      pending_o <= expected_chars.size();
    end
  end

endmodule

[test/format_string_integer_printer_tb.sv]
// Testbench top of the integer printf engine: clock, reset, format beats and output stalls.
// Depends on fsip_pkg, format_string_integer_printer and printf_stream_checker.
module format_string_integer_printer_tb;
  import fsip_pkg::*;

  localparam int unsigned MaxWidth     = 48;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongRunDirs  = 3;
  localparam logic [7:0]  ChLowS       = 8'h73;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [15:0] cfg_wdata_i     = 16'd0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  fmt_char_i      = 8'd0;
  logic [31:0] arg_value_i     = 32'd0;
  logic        end_of_format_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [7:0]  out_char_o;
  logic [15:0] position_o;
  logic        fits_o;
  logic        is_terminator_o;
  logic [15:0] total_count_o;
  logic        last_of_run_o;

  int unsigned chars_pending;
  int unsigned mismatch_total;
  int unsigned cycle_count = 0;
  int unsigned sent_items  = 0;
  logic        calm        = 1'b0;

  format_string_integer_printer #(
    .MAX_WIDTH(MaxWidth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .fmt_char_i     (fmt_char_i),
    .arg_value_i    (arg_value_i),
    .end_of_format_i(end_of_format_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .position_o     (position_o),
    .fits_o         (fits_o),
    .is_terminator_o(is_terminator_o),
    .total_count_o  (total_count_o),
    .last_of_run_o  (last_of_run_o)
  );

  printf_stream_checker #(
    .MaxWidth(MaxWidth)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .fmt_char_i     (fmt_char_i),
    .arg_value_i    (arg_value_i),
    .end_of_format_i(end_of_format_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_i     (out_char_o),
    .position_i     (position_o),
    .fits_i         (fits_o),
    .is_terminator_i(is_terminator_o),
    .total_count_i  (total_count_o),
    .last_of_run_i  (last_of_run_o),
    .pending_o      (chars_pending),
    .failures_o     (mismatch_total)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Unless calm is set, the receiver drops ready for a random gap before each output beat.
  initial begin
    int unsigned gap;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(input logic [7:0] fmt, input logic [31:0] arg, input logic eof);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    fmt_char_i      <= fmt;
    arg_value_i     <= arg;
    end_of_format_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
  endtask

  task automatic send_char(input logic [7:0] fmt);
    send_item(fmt, $urandom, 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom), $urandom, 1'b1);
  endtask

  task automatic send_width(input int unsigned width);
    if (width >= 100) send_char(ChZero + 8'(width / 100));
    if (width >= 10) send_char(ChZero + 8'((width / 10) % 10));
    if (width != 0) send_char(ChZero + 8'(width % 10));
  endtask

  task automatic send_directive(input logic zero_flag, input int unsigned width,
                                input logic [7:0] letter, input logic [31:0] arg);
    send_char(ChPct);
    if (zero_flag) send_char(ChZero);
    send_width(width);
    send_item(letter, arg, 1'b0);
  endtask

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(1, 9);
      2:       return $urandom_range(10, MaxWidth);
      default: return $urandom_range(MaxWidth + 1, 999);
    endcase
  endfunction

  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    logic [7:0]  letter;
    start = sent_items;
    while (sent_items - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_char(8'($urandom));
        end
        8: begin
          send_end();
        end
        9: begin
          // A directive broken off by the end beat.
          send_char(ChPct);
          if ($urandom_range(0, 1) != 0) send_char(ChZero);
          send_width($urandom_range(0, 1) != 0 ? pick_width() : 0);
          send_end();
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       letter = ChPct;
            1:       letter = ChC;
            2:       letter = ChD;
            3:       letter = ChU;
            4:       letter = ChX;
            default: letter = 8'($urandom);
          endcase
          send_directive($urandom_range(0, 2) == 0, pick_width(), letter, pick_arg());
        end
      endcase
    end
    send_end();
  endtask

  // Waits until every predicted beat has arrived and the engine has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (chars_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_buffer_size(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_char(8'h41);
    send_char(ChNul);
    send_char(8'hFF);
    send_char(ChPct);
    send_char(ChPct);
    send_directive(1'b1, 5, ChD, -32'sd42);
    send_directive(1'b0, 6, ChD, 32'h8000_0000);
    send_directive(1'b0, 3, ChC, 32'hFFFF_FF41);
    send_directive(1'b0, 0, ChX, 32'hFFFF_FFFF);
    send_directive(1'b0, 0, ChLowS, 32'h1234_5678);
    send_directive(1'b0, 99, ChU, 32'h0000_0000);
    send_char(ChPct);
    send_char(ChZero);
    send_end();
    settle();

    write_buffer_size(16'd0);
    run_random(20);
    settle();

    calm = 1'b1;
    write_buffer_size(16'd1);
    run_random(15);
    settle();

    // A short format string of the widest fields with the largest buffer.
    write_buffer_size(16'hFFFF);
    for (int unsigned i = 0; i < LongRunDirs; i++) begin
      send_directive(i % 3 == 0, MaxWidth, i % 2 != 0 ? ChC : ChX, $urandom);
    end
    send_end();
    settle();

    calm = 1'b0;
    write_buffer_size(16'($urandom_range(2, 64)));
    run_random(25);
    settle();

    if (mismatch_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
